### hdl/assert_macros.svh
// assertion helpers for the rgb to hsl conversion core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define HSL_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsl assertion failed");
// concurrent check on the block clock and reset
`define HSL_ASSERT(lbl, prop) \
    `HSL_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define HSL_ASSERT_CLK(lbl, clk, rst_n, prop)
`define HSL_ASSERT(lbl, prop)
`endif

`endif

### hdl/hsl_pkg.sv
package hsl_pkg;

    localparam int CH_W   = 8;            // one color channel
    localparam int SUM_W  = 9;            // max + min
    localparam int HUE_W  = 13;           // hue in 1/16 degree
    localparam int SAT_W  = 8;
    localparam int NUM_W  = 11;           // hue numerator k*d + diff, below 6*255
    localparam int DVD_W  = 21;           // dividend, 960 * numerator fits here
    localparam int DVS_W  = 9;            // divisor, d or den
    localparam int Q_W    = 13;           // quotient bits, one per divider stage
    localparam int N_DIV  = Q_W;
    localparam int N_FRONT = 2;           // front stages ahead of the dividers
    localparam int N_STG  = N_DIV + N_FRONT;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [N_DIV-1:0] load;           // per divider stage load enable
    } t_div_ctl;

endpackage

### hdl/hsl_front.sv
module hsl_front (
    input  logic                        i_clk,
    input  logic [hsl_pkg::N_FRONT-1:0] i_load,
    input  logic [hsl_pkg::CH_W-1:0]    i_red,
    input  logic [hsl_pkg::CH_W-1:0]    i_green,
    input  logic [hsl_pkg::CH_W-1:0]    i_blue,
    output logic [hsl_pkg::DVD_W-1:0]   o_hue_dvd,
    output logic [hsl_pkg::DVS_W-1:0]   o_hue_dvs,
    output logic [hsl_pkg::DVD_W-1:0]   o_sat_dvd,
    output logic [hsl_pkg::DVS_W-1:0]   o_sat_dvs,
    output logic [hsl_pkg::SUM_W-1:0]   o_sum
);
    import hsl_pkg::*;

    // first stage: max, min, spread, sum, saturation divisor, hue sector
    logic [CH_W-1:0]          mx;
    logic [CH_W-1:0]          mn;
    logic [CH_W-1:0]          d;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W-1:0]         den;
    logic signed [CH_W:0]     diff;
    logic [1:0]               kh;        // sector offset in units of 2*d
    logic                     achro;
    logic [CH_W-1:0]          r_d;
    logic [SUM_W-1:0]         r_den;
    logic [SUM_W-1:0]         r_lsum;
    logic signed [CH_W:0]     r_diff;
    logic [1:0]               r_kh;
    logic                     r_achro;
    // second stage: hue numerator and both dividends
    logic [NUM_W-1:0]         kd;
    logic signed [NUM_W:0]    num_s;
    logic [NUM_W-1:0]         num;
    logic [DVD_W-1:0]         n_hue_dvd;
    logic [DVS_W-1:0]         n_hue_dvs;
    logic [DVD_W-1:0]         n_sat_dvd;
    logic [DVS_W-1:0]         n_sat_dvs;
    logic [DVD_W-1:0]         r_hue_dvd;
    logic [DVS_W-1:0]         r_hue_dvs;
    logic [DVD_W-1:0]         r_sat_dvd;
    logic [DVS_W-1:0]         r_sat_dvs;
    logic [SUM_W-1:0]         r_sum;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (mx > i_blue) ? mx : i_blue;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (mn < i_blue) ? mn : i_blue;
        d     = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        achro = (mx == mn);
        den   = (sum > SUM_W'(255)) ? (SUM_W'(510) - sum) : sum;

        // first match decides: red, then green, then blue
        if (mx == i_red) begin
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            kh   = (i_green < i_blue) ? 2'd3 : 2'd0;
        end else if (mx == i_green) begin
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            kh   = 2'd1;
        end else begin
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            kh   = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_d     <= d;
            r_den   <= den;
            r_lsum  <= sum;
            r_diff  <= diff;
            r_kh    <= kh;
            r_achro <= achro;
        end
    end

    always_comb begin
        kd = (r_kh[1] ? {1'b0, r_d, 2'b0} : NUM_W'(0))
           + (r_kh[0] ? {2'b0, r_d, 1'b0} : NUM_W'(0));
        num_s = $signed({1'b0, kd}) + $signed({{(NUM_W-CH_W){r_diff[CH_W]}}, r_diff});
        num = num_s[NUM_W-1:0];

        // achromatic: zero over one gives zero for both quotients
        if (r_achro) begin
            n_hue_dvd = '0;
            n_hue_dvs = DVS_W'(1);
            n_sat_dvd = '0;
            n_sat_dvs = DVS_W'(1);
        end else begin
            // 960 = 1024 - 64
            n_hue_dvd = ({num, 10'b0}) - DVD_W'({num, 6'b0});
            n_hue_dvs = {1'b0, r_d};
            // 255 = 256 - 1
            n_sat_dvd = DVD_W'({r_d, 8'b0}) - DVD_W'(r_d);
            n_sat_dvs = r_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_hue_dvd <= n_hue_dvd;
            r_hue_dvs <= n_hue_dvs;
            r_sat_dvd <= n_sat_dvd;
            r_sat_dvs <= n_sat_dvs;
            r_sum     <= r_lsum;
        end
    end

    assign o_hue_dvd = r_hue_dvd;
    assign o_hue_dvs = r_hue_dvs;
    assign o_sat_dvd = r_sat_dvd;
    assign o_sat_dvs = r_sat_dvs;
    assign o_sum     = r_sum;

endmodule

### hdl/hsl_div.sv
module hsl_div (
    input  logic                        i_clk,
    input  hsl_pkg::t_div_ctl           i_ctl,
    input  logic [hsl_pkg::DVD_W-1:0]   i_dvd,
    input  logic [hsl_pkg::DVS_W-1:0]   i_dvs,
    output logic [hsl_pkg::Q_W-1:0]     o_quo
);
    import hsl_pkg::*;

    // restoring division, one quotient bit per stage, msb first;
    // the caller guarantees the quotient fits in Q_W bits
    logic [DVD_W-1:0] r_rem [N_DIV];
    logic [DVS_W-1:0] r_dvs [N_DIV];
    logic [Q_W-1:0]   r_quo [N_DIV];

    for (genvar k = 0; k < N_DIV; k++) begin : g_stg
        localparam int SH = Q_W - 1 - k;
        logic [DVD_W-1:0] rem_in;
        logic [DVS_W-1:0] dvs_in;
        logic [Q_W-1:0]   quo_in;
        logic [DVD_W:0]   trial;
        logic             take;
        logic [DVD_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign rem_in = i_dvd;
            assign dvs_in = i_dvs;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvs_in = r_dvs[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            trial = (DVD_W+1)'(dvs_in) << SH;
            take  = ({1'b0, rem_in} >= trial);
            n_rem = take ? (rem_in - trial[DVD_W-1:0]) : rem_in;
            n_quo = quo_in | (Q_W'(take) << SH);
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[k]) begin
                r_rem[k] <= n_rem;
                r_dvs[k] <= dvs_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[N_DIV-1];

endmodule

### hdl/rgb_to_hsl_conversion_core.sv
// rgb to hsl conversion core
// slave channel (s_axis) takes one rgb pixel per item: red, green, blue,
// 8 bits each, unsigned. master channel (m_axis) gives one result item per
// pixel, in order: hue in 1/16 degree (0..5759), saturation (0..255) and
// lightness as max+min (0..510).
// the pipeline has 15 register stages: two front stages (max, min, spread,
// sum and saturation divisor, then the hue numerator and both dividends) and
// 13 stages of two restoring dividers running side by side, one quotient bit
// per stage. throughput is one item per cycle while the receiver takes
// results; the divider stage count sets the pipeline depth, not the rate.
// every stage has its own valid bit and takes a new item whenever it is
// empty or the stage after it moves, so empty stages fill up while the
// receiver stalls and nothing is lost or repeated.
// the last stage is the output register: results wait there while
// i_m_axis_tready is low, and input items are still taken until all
// stages hold an item.
// reset (i_rst_n low, synchronous) empties all stages; the block has no
// other state and no configuration.
`include "assert_macros.svh"

module rgb_to_hsl_conversion_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [hsl_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // hsl out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [12:0] hue_out, [20:13] saturation_out, [29:21] lightness_sum, [31:30] zero
    output logic [hsl_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import hsl_pkg::*;

    // valid bit per stage: 0 and 1 are the front stages, N_STG-1 the output register
    logic [N_STG-1:0] r_valid;
    logic [N_STG-1:0] n_valid;
    logic [N_STG-1:0] rdy;       // stage may load this cycle

    logic [DVD_W-1:0] hue_dvd;
    logic [DVS_W-1:0] hue_dvs;
    logic [DVD_W-1:0] sat_dvd;
    logic [DVS_W-1:0] sat_dvs;
    logic [SUM_W-1:0] front_sum;
    logic [Q_W-1:0]   hue_quo;
    logic [Q_W-1:0]   sat_quo;
    t_div_ctl         div_ctl;

    // lightness rides alongside the divider stages
    logic [SUM_W-1:0] r_sum [N_DIV];

    // ready ripples back from the output: a stage loads when empty or moving
    always_comb begin
        rdy[N_STG-1] = !r_valid[N_STG-1] || i_m_axis_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (rdy[0]) begin
            n_valid[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < N_STG; k++) begin
            if (rdy[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
        div_ctl.load = rdy[N_STG-1:N_FRONT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    hsl_front u_front (
        .i_clk     (i_clk),
        .i_load    (rdy[N_FRONT-1:0]),
        .i_red     (i_s_axis_tdata[CH_W-1:0]),
        .i_green   (i_s_axis_tdata[2*CH_W-1:CH_W]),
        .i_blue    (i_s_axis_tdata[3*CH_W-1:2*CH_W]),
        .o_hue_dvd (hue_dvd),
        .o_hue_dvs (hue_dvs),
        .o_sat_dvd (sat_dvd),
        .o_sat_dvs (sat_dvs),
        .o_sum     (front_sum)
    );

    // hue = floor(960*num / d)
    hsl_div u_hue_div (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_dvd (hue_dvd),
        .i_dvs (hue_dvs),
        .o_quo (hue_quo)
    );

    // saturation = floor(255*d / den), always below 256
    hsl_div u_sat_div (
        .i_clk (i_clk),
        .i_ctl (div_ctl),
        .i_dvd (sat_dvd),
        .i_dvs (sat_dvs),
        .o_quo (sat_quo)
    );

    always_ff @(posedge i_clk) begin
        if (div_ctl.load[0]) begin
            r_sum[0] <= front_sum;
        end
        for (int k = 1; k < N_DIV; k++) begin
            if (div_ctl.load[k]) begin
                r_sum[k] <= r_sum[k-1];
            end
        end
    end

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_valid[N_STG-1];
    assign o_m_axis_tdata  = {2'b00, r_sum[N_DIV-1], sat_quo[SAT_W-1:0], hue_quo[HUE_W-1:0]};

    // an accepted pixel always lands in the front stage
    `HSL_ASSERT(a_in_lands, (i_s_axis_tvalid && o_s_axis_tready) |=> r_valid[0])
    // hue never reaches a full circle
    `HSL_ASSERT(a_hue_range, o_m_axis_tvalid |-> (o_m_axis_tdata[12:0] <= 13'd5759))
    // zero saturation only for gray pixels, which also have zero hue
    `HSL_ASSERT_CLK(a_gray_hue, i_clk, i_rst_n,
        (o_m_axis_tvalid && (o_m_axis_tdata[20:13] == 8'd0)) |-> (o_m_axis_tdata[12:0] == 13'd0))
    // saturation quotient never spills past 8 bits
    `HSL_ASSERT(a_sat_fits, o_m_axis_tvalid |-> (sat_quo[Q_W-1:SAT_W] == '0))

endmodule
